### rtl/btc_pkg.sv
// Package for the balanced-ternary converter: stage types, opcodes and
// small conversion functions. No dependencies.
package btc_pkg;

    typedef enum logic [1:0] {
        OP_BYTE_TO_TRITS = 2'd0,
        OP_TRITS_TO_BYTE = 2'd1,
        OP_CHAR_TO_TRITS = 2'd2,
        OP_TRITS_TO_CHAR = 2'd3
    } op_t;

    localparam int NumTrits   = 5;
    localparam int InWidth    = 24;
    localparam int OutWidth   = 24;

    localparam logic [7:0] ByteMaxLow  = 8'd121;
    localparam logic [7:0] ByteMax     = 8'd242;
    localparam logic [7:0] ByteBias    = 8'd121;
    localparam logic [7:0] ByteWrap    = 8'd122;
    localparam logic [8:0] ByteModulus = 9'd243;
    localparam logic [7:0] CharNine    = 8'h39;
    localparam logic [7:0] CharA       = 8'h41;
    localparam logic [7:0] CharM       = 8'h4D;
    localparam logic [7:0] CharN       = 8'h4E;
    localparam logic [7:0] CharZ       = 8'h5A;
    localparam logic [7:0] CharZeroOffset = 8'd13;
    localparam logic [7:0] CharAOffset    = 8'd51;

    localparam logic [7:0] Alphabet [27] = '{
        8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56,
        8'h57, 8'h58, 8'h59, 8'h5A, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44,
        8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4A, 8'h4B, 8'h4C, 8'h4D
    };

    typedef struct packed {
        op_t               op;
        logic [2:0]        n;
        logic              good;
        logic [7:0]        v;
        logic signed [1:0] d4;
        logic signed [1:0] d3;
        logic signed [1:0] d2;
        logic signed [1:0] d1;
        logic signed [1:0] d0;
    } s1_t;

    typedef struct packed {
        op_t               op;
        logic [2:0]        n;
        logic              good;
        logic [3:0]        hi;
        logic [4:0]        lo;
        logic signed [8:0] sum_lo;
        logic signed [8:0] sum_hi;
    } s2_t;

    typedef struct packed {
        logic       ok;
        logic [9:0] trits_out;
        logic [7:0] value_out;
    } res_t;

    function automatic logic signed [1:0] code_to_trit(input logic [1:0] code);
        logic signed [1:0] t;
        case (code)
            2'd1:    t = 2'sd1;
            2'd2:    t = -2'sd1;
            default: t = 2'sd0;
        endcase
        return t;
    endfunction

    // offset digit (0,1,2 meaning -1,0,+1) to packed trit code
    function automatic logic [1:0] digit_to_code(input logic [1:0] d);
        logic [1:0] c;
        case (d)
            2'd0:    c = 2'd2;
            2'd2:    c = 2'd1;
            default: c = 2'd0;
        endcase
        return c;
    endfunction

    // three base-3 digits of x (x < 27), lowest digit in bits 1:0
    function automatic logic [5:0] split3(input logic [4:0] x);
        logic [1:0] q2;
        logic [1:0] q1;
        logic [4:0] r;
        logic [4:0] q0;
        q2 = (x >= 5'd18) ? 2'd2 : ((x >= 5'd9) ? 2'd1 : 2'd0);
        r  = x - 5'(q2) * 5'd9;
        q1 = (r >= 5'd6) ? 2'd2 : ((r >= 5'd3) ? 2'd1 : 2'd0);
        q0 = r - 5'(q1) * 5'd3;
        return {q2, q1, q0[1:0]};
    endfunction

endpackage

### rtl/btc_front.sv
// First stage: clamps the count, classifies the input and maps codes to trits.
// Depends on btc_pkg.
module btc_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           ce,
    input  logic           in_valid,
    input  btc_pkg::op_t   op,
    input  logic [7:0]     value_in,
    input  logic [9:0]     trits_in,
    input  logic [2:0]     trit_count,
    output logic           valid_reg,
    output btc_pkg::s1_t   data_reg
);

    btc_pkg::s1_t data_next;
    logic [2:0]   cnt;
    logic [2:0]   n;
    logic signed [1:0] d [btc_pkg::NumTrits];

    always_comb begin
        cnt = (trit_count > 3'd5) ? 3'd5 : trit_count;
        n   = (op[1] && cnt > 3'd3) ? 3'd3 : cnt;
        for (int k = 0; k < btc_pkg::NumTrits; k++) begin
            d[k] = (3'(k) < n) ? btc_pkg::code_to_trit(trits_in[2*k +: 2]) : 2'sd0;
        end

        data_next.op   = op;
        data_next.n    = n;
        data_next.good = 1'b1;
        data_next.v    = 8'd0;
        data_next.d0   = d[0];
        data_next.d1   = d[1];
        data_next.d2   = d[2];
        data_next.d3   = d[3];
        data_next.d4   = d[4];

        case (op)
            btc_pkg::OP_BYTE_TO_TRITS: begin
                data_next.good = (value_in <= btc_pkg::ByteMax);
                data_next.v    = (value_in <= btc_pkg::ByteMaxLow)
                               ? value_in + btc_pkg::ByteBias
                               : value_in - btc_pkg::ByteWrap;
            end
            btc_pkg::OP_CHAR_TO_TRITS: begin
                if (value_in inside {[btc_pkg::CharN:btc_pkg::CharZ]}) begin
                    data_next.v = value_in - btc_pkg::CharN;
                end else if (value_in inside {[btc_pkg::CharA:btc_pkg::CharM]}) begin
                    data_next.v = value_in - btc_pkg::CharAOffset;
                end else if (value_in == btc_pkg::CharNine) begin
                    data_next.v = btc_pkg::CharZeroOffset;
                end else begin
                    data_next.good = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ce) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            data_reg <= data_next;
        end
    end

endmodule

### rtl/btc_mid.sv
// Second stage: splits the offset value by 27 and forms partial trit sums.
// Depends on btc_pkg.
module btc_mid (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           ce,
    input  logic           in_valid,
    input  btc_pkg::s1_t   in_data,
    output logic           valid_reg,
    output btc_pkg::s2_t   data_reg
);

    btc_pkg::s2_t data_next;
    logic [3:0]   hi;

    always_comb begin
        hi = 4'd0;
        for (int k = 1; k <= 8; k++) begin
            if (in_data.v >= 8'(27 * k)) begin
                hi = 4'(k);
            end
        end
        data_next.op     = in_data.op;
        data_next.n      = in_data.n;
        data_next.good   = in_data.good;
        data_next.hi     = hi;
        data_next.lo     = 5'(in_data.v - 8'(hi) * 8'd27);
        data_next.sum_lo = 9'(in_data.d0) + 9'(in_data.d1) * 9'sd3
                         + 9'(in_data.d2) * 9'sd9;
        data_next.sum_hi = 9'(in_data.d3) * 9'sd27 + 9'(in_data.d4) * 9'sd81;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ce) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            data_reg <= data_next;
        end
    end

endmodule

### rtl/btc_back.sv
// Third stage: forms the digits or the decoded value and holds the result.
// Depends on btc_pkg.
module btc_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           ce,
    input  logic           in_valid,
    input  btc_pkg::s2_t   in_data,
    output logic           valid_reg,
    output btc_pkg::res_t  data_reg
);

    btc_pkg::res_t     data_next;
    logic signed [8:0] total;
    logic [8:0]        wrapped;
    logic [4:0]        idx;
    logic [5:0]        lo_dig;
    logic [5:0]        hi_dig;
    logic [1:0]        dd [btc_pkg::NumTrits];
    logic [2:0]        len;
    logic              fail;
    logic [9:0]        codes;

    always_comb begin
        total   = in_data.sum_lo + in_data.sum_hi;
        wrapped = (total < 0) ? 9'(total) + btc_pkg::ByteModulus : 9'(total);
        idx     = 5'(total + 9'sd13);
        lo_dig  = btc_pkg::split3(in_data.lo);
        hi_dig  = btc_pkg::split3(in_data.hi[3:0] > 4'd8 ? 5'd8 : 5'(in_data.hi));
        dd[0]   = lo_dig[1:0];
        dd[1]   = lo_dig[3:2];
        dd[2]   = lo_dig[5:4];
        dd[3]   = hi_dig[1:0];
        dd[4]   = hi_dig[3:2];
        len     = (in_data.op == btc_pkg::OP_CHAR_TO_TRITS) ? 3'd3 : 3'd5;
        fail    = 1'b0;
        codes   = 10'd0;
        for (int k = 0; k < btc_pkg::NumTrits; k++) begin
            if (3'(k) < in_data.n) begin
                codes[2*k +: 2] = btc_pkg::digit_to_code(dd[k]);
            end else if (3'(k) < len && dd[k] != 2'd1) begin
                fail = 1'b1;
            end
        end

        data_next = '0;
        case (in_data.op)
            btc_pkg::OP_TRITS_TO_BYTE: begin
                data_next.value_out = wrapped[7:0];
                data_next.ok        = 1'b1;
            end
            btc_pkg::OP_TRITS_TO_CHAR: begin
                data_next.value_out = (idx < 5'd27) ? btc_pkg::Alphabet[idx] : 8'd0;
                data_next.ok        = 1'b1;
            end
            default: begin
                if (in_data.good && !fail) begin
                    data_next.trits_out = codes;
                    data_next.ok        = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ce) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            data_reg <= data_next;
        end
    end

endmodule

### rtl/balanced_ternary_converter.sv
// Balanced-ternary converter, top level: three register stages with one
// shared advance enable. Depends on btc_pkg, btc_front, btc_mid, btc_back.
// Throughput: one transfer per cycle; the whole pipe halts while a result
// waits on m_tready, set by the output register stage.
// Reset: aresetn synchronous, active low, clears all stage valid bits.
module balanced_ternary_converter (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // opcode[1:0]
    input  logic [1:0]                    s_tuser,
    // value_in[7:0], trits_in[17:8], trit_count[20:18], zero pad
    input  logic [btc_pkg::InWidth-1:0]   s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // ok
    output logic                          m_tuser,
    // value_out[7:0], trits_out[17:8], zero pad
    output logic [btc_pkg::OutWidth-1:0]  m_tdata
);

    logic          ce;
    logic          s1_valid;
    btc_pkg::s1_t  s1_data;
    logic          s2_valid;
    btc_pkg::s2_t  s2_data;
    btc_pkg::res_t res;

    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    btc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ce         (ce),
        .in_valid   (s_tvalid),
        .op         (btc_pkg::op_t'(s_tuser)),
        .value_in   (s_tdata[7:0]),
        .trits_in   (s_tdata[17:8]),
        .trit_count (s_tdata[20:18]),
        .valid_reg  (s1_valid),
        .data_reg   (s1_data)
    );

    btc_mid u_mid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s1_valid),
        .in_data   (s1_data),
        .valid_reg (s2_valid),
        .data_reg  (s2_data)
    );

    btc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s2_valid),
        .in_data   (s2_data),
        .valid_reg (m_tvalid),
        .data_reg  (res)
    );

    assign m_tdata = {6'd0, res.trits_out, res.value_out};
    assign m_tuser = res.ok;

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench for balanced_ternary_converter: a directed table, then random transfers
// under three idling regimes, each checked against a typed or predicted result.
// Depends on btc_pkg and the converter RTL.
module tb_top;

    localparam int CycleLimit  = 200000;
    localparam int DrainCycles = 12;
    localparam int RandomItems = 1425;
    localparam int HoldCycles  = 80;
    localparam int TxIdle [3]  = '{10, 74, 0};
    localparam int RxIdle [3]  = '{74, 10, 0};

    localparam int HalfSpan = 121;
    localparam int TopByte  = 242;
    localparam int Modulus  = 243;
    localparam int CharBias = 13;

    localparam logic [1:0] TritZero  = 2'd0;
    localparam logic [1:0] TritPlus  = 2'd1;
    localparam logic [1:0] TritMinus = 2'd2;

    localparam logic [7:0] ChrNine = "9";
    localparam logic [7:0] ChrA    = "A";
    localparam logic [7:0] ChrM    = "M";
    localparam logic [7:0] ChrN    = "N";
    localparam logic [7:0] ChrZ    = "Z";
    localparam logic [7:0] ChrAt   = "@";

    typedef struct packed {
        logic       ok;
        logic [9:0] trits;
        logic [7:0] value;
    } conv_res_t;

    typedef struct packed {
        btc_pkg::op_t op;
        logic [7:0]   value;
        logic [9:0]   trits;
        logic [2:0]   count;
        logic         known;
        conv_res_t    res;
    } dir_row_t;

    localparam conv_res_t NoRes = '0;

    // known = 1: expected result typed in; otherwise predicted
    localparam dir_row_t DirectedRows [26] = '{
        '{btc_pkg::OP_BYTE_TO_TRITS, 8'd0,    10'h000, 3'd5, 1'b1, '{1'b1, 10'h000, 8'd0}},
        '{btc_pkg::OP_BYTE_TO_TRITS, 8'd1,    10'h000, 3'd5, 1'b1, '{1'b1, 10'h001, 8'd0}},
        '{btc_pkg::OP_BYTE_TO_TRITS, 8'd121,  10'h000, 3'd5, 1'b1, '{1'b1, 10'h155, 8'd0}},
        '{btc_pkg::OP_BYTE_TO_TRITS, 8'd122,  10'h000, 3'd5, 1'b1, '{1'b1, 10'h2AA, 8'd0}},
        '{btc_pkg::OP_BYTE_TO_TRITS, 8'd242,  10'h000, 3'd5, 1'b1, '{1'b1, 10'h002, 8'd0}},
        '{btc_pkg::OP_BYTE_TO_TRITS, 8'd243,  10'h000, 3'd5, 1'b1, '{1'b0, 10'h000, 8'd0}},
        '{btc_pkg::OP_BYTE_TO_TRITS, 8'd255,  10'h3FF, 3'd7, 1'b1, '{1'b0, 10'h000, 8'd0}},
        '{btc_pkg::OP_BYTE_TO_TRITS, 8'd1,    10'h000, 3'd0, 1'b1, '{1'b0, 10'h000, 8'd0}},
        '{btc_pkg::OP_BYTE_TO_TRITS, 8'd0,    10'h000, 3'd0, 1'b1, '{1'b1, 10'h000, 8'd0}},
        '{btc_pkg::OP_BYTE_TO_TRITS, 8'd9,    10'h3FF, 3'd2, 1'b0, NoRes},
        '{btc_pkg::OP_TRITS_TO_BYTE, 8'd0,    10'h155, 3'd5, 1'b1, '{1'b1, 10'h000, 8'd121}},
        '{btc_pkg::OP_TRITS_TO_BYTE, 8'd0,    10'h2AA, 3'd5, 1'b1, '{1'b1, 10'h000, 8'd122}},
        '{btc_pkg::OP_TRITS_TO_BYTE, 8'd255,  10'h3FF, 3'd5, 1'b1, '{1'b1, 10'h000, 8'd0}},
        '{btc_pkg::OP_TRITS_TO_BYTE, 8'd0,    10'h2AA, 3'd0, 1'b1, '{1'b1, 10'h000, 8'd0}},
        '{btc_pkg::OP_TRITS_TO_BYTE, 8'd0,    10'h19B, 3'd6, 1'b0, NoRes},
        '{btc_pkg::OP_CHAR_TO_TRITS, ChrA,    10'h000, 3'd3, 1'b0, NoRes},
        '{btc_pkg::OP_CHAR_TO_TRITS, ChrM,    10'h000, 3'd3, 1'b1, '{1'b1, 10'h015, 8'd0}},
        '{btc_pkg::OP_CHAR_TO_TRITS, ChrN,    10'h000, 3'd3, 1'b1, '{1'b1, 10'h02A, 8'd0}},
        '{btc_pkg::OP_CHAR_TO_TRITS, ChrZ,    10'h3FF, 3'd5, 1'b0, NoRes},
        '{btc_pkg::OP_CHAR_TO_TRITS, ChrNine, 10'h000, 3'd0, 1'b1, '{1'b1, 10'h000, 8'd0}},
        '{btc_pkg::OP_CHAR_TO_TRITS, ChrAt,   10'h000, 3'd3, 1'b1, '{1'b0, 10'h000, 8'd0}},
        '{btc_pkg::OP_CHAR_TO_TRITS, ChrM,    10'h000, 3'd2, 1'b1, '{1'b0, 10'h000, 8'd0}},
        '{btc_pkg::OP_TRITS_TO_CHAR, 8'd0,    10'h000, 3'd3, 1'b1, '{1'b1, 10'h000, ChrNine}},
        '{btc_pkg::OP_TRITS_TO_CHAR, 8'd0,    10'h3FF, 3'd5, 1'b1, '{1'b1, 10'h000, ChrNine}},
        '{btc_pkg::OP_TRITS_TO_CHAR, 8'd0,    10'h015, 3'd3, 1'b1, '{1'b1, 10'h000, ChrM}},
        '{btc_pkg::OP_TRITS_TO_CHAR, 8'd0,    10'h2AA, 3'd7, 1'b1, '{1'b1, 10'h000, ChrN}}
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [1:0]  s_tuser  = '0;
    logic [23:0] s_tdata  = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic        m_tuser;
    logic [23:0] m_tdata;

    conv_res_t expected_results [$];
    int        errors     = 0;
    int        cycles     = 0;
    int        idle_phase = 0;
    int        hold_left  = 0;
    bit        hold_done  = 1'b0;

    balanced_ternary_converter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    function automatic int balanced_limit(input int n);
        return (3 ** n - 1) / 2;
    endfunction

    function automatic logic [7:0] char_of(input int t);
        int idx;
        idx = t + CharBias;
        if (idx < CharBias)
            return 8'(int'(ChrN) + idx);
        if (idx == CharBias)
            return ChrNine;
        return 8'(int'(ChrA) + idx - CharBias - 1);
    endfunction

    function automatic int trit_sum(input logic [9:0] trits, input int n);
        int sum;
        int weight;
        sum = 0;
        weight = 1;
        for (int k = 0; k < n; k++) begin
            case (trits[2*k +: 2])
                TritPlus:  sum += weight;
                TritMinus: sum -= weight;
                default: ;
            endcase
            weight *= 3;
        end
        return sum;
    endfunction

    // offset digits 0/1/2 stand for -1/0/+1; result is {ok, trits}
    function automatic logic [10:0] encode_balanced(input int offset, input int len, input int n);
        logic [9:0] packed_trits;
        int v;
        int d;
        packed_trits = '0;
        v = offset;
        for (int k = 0; k < len; k++) begin
            d = v % 3;
            v = v / 3;
            if (k >= n) begin
                if (d != 1)
                    return 11'd0;
            end else begin
                packed_trits[2*k +: 2] = (d == 0) ? TritMinus : ((d == 2) ? TritPlus : TritZero);
            end
        end
        return {1'b1, packed_trits};
    endfunction

    function automatic conv_res_t predict_conversion(input btc_pkg::op_t op,
                                                     input logic [7:0] value,
                                                     input logic [9:0] trits,
                                                     input logic [2:0] count);
        conv_res_t res;
        int n;
        int n3;
        int t;
        bit good;
        res = '0;
        n = (count > 3'd5) ? 5 : int'(count);
        n3 = (n > 3) ? 3 : n;
        good = 1'b1;
        t = 0;
        case (op)
            btc_pkg::OP_BYTE_TO_TRITS: begin
                if (int'(value) <= TopByte) begin
                    t = int'(value);
                    if (t > HalfSpan)
                        t -= Modulus;
                    {res.ok, res.trits} = encode_balanced(t + HalfSpan, 5, n);
                end
            end
            btc_pkg::OP_TRITS_TO_BYTE: begin
                t = trit_sum(trits, n);
                if (t < 0)
                    t += Modulus;
                res.value = 8'(t);
                res.ok = 1'b1;
            end
            btc_pkg::OP_CHAR_TO_TRITS: begin
                if (value inside {[ChrN:ChrZ]})
                    t = int'(value) - int'(ChrN) - CharBias;
                else if (value inside {[ChrA:ChrM]})
                    t = int'(value) - int'(ChrA) + 1;
                else if (value != ChrNine)
                    good = 1'b0;
                if (good)
                    {res.ok, res.trits} = encode_balanced(t + CharBias, 3, n3);
            end
            default: begin
                res.value = char_of(trit_sum(trits, n3));
                res.ok = 1'b1;
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s mismatch, got %0h expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic pick_random(output btc_pkg::op_t op, output logic [7:0] value,
                               output logic [9:0] trits, output logic [2:0] count);
        int lim;
        int t;
        op = btc_pkg::op_t'($urandom_range(0, 3));
        value = 8'($urandom);
        trits = 10'($urandom);
        if ($urandom_range(0, 9) < 6)
            count = (op inside {btc_pkg::OP_BYTE_TO_TRITS, btc_pkg::OP_TRITS_TO_BYTE})
                  ? 3'd5 : 3'd3;
        else
            count = 3'($urandom_range(0, 7));
        // mostly values that fit in the available trits
        if (op == btc_pkg::OP_BYTE_TO_TRITS && $urandom_range(0, 9) < 8) begin
            lim = balanced_limit((count > 3'd5) ? 5 : int'(count));
            t = int'($urandom_range(0, 2 * lim)) - lim;
            value = 8'((t < 0) ? t + Modulus : t);
        end else if (op == btc_pkg::OP_CHAR_TO_TRITS && $urandom_range(0, 9) < 8) begin
            lim = balanced_limit((count > 3'd3) ? 3 : int'(count));
            t = int'($urandom_range(0, 2 * lim)) - lim;
            value = char_of(t);
        end
    endtask

    task automatic offer_item(input btc_pkg::op_t op, input logic [7:0] value,
                              input logic [9:0] trits, input logic [2:0] count,
                              input logic known, input conv_res_t typed_res);
        while ($urandom_range(0, 99) < TxIdle[idle_phase]) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b0, count, trits, value};
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(known ? typed_res
                                         : predict_conversion(op, value, trits, count));
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // result side: random back-pressure, one long hold once the last phase starts
    always @(posedge aclk) begin
        if (idle_phase == 2 && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HoldCycles;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= RxIdle[idle_phase]);
        end
    end

    always @(posedge aclk) begin
        conv_res_t got;
        conv_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata[17:0]};
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected transfer", int'(got), 0);
            end else begin
                want = expected_results.pop_front();
                if (got.value != want.value)
                    report_mismatch("value_out", int'(got.value), int'(want.value));
                if (got.trits != want.trits)
                    report_mismatch("trits_out", int'(got.trits), int'(want.trits));
                if (got.ok != want.ok)
                    report_mismatch("ok", int'(got.ok), int'(want.ok));
            end
        end
    end

    initial begin
        btc_pkg::op_t op;
        logic [7:0]   value;
        logic [9:0]   trits;
        logic [2:0]   count;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (DirectedRows[i])
            offer_item(DirectedRows[i].op, DirectedRows[i].value, DirectedRows[i].trits,
                       DirectedRows[i].count, DirectedRows[i].known, DirectedRows[i].res);
        for (int i = 0; i < RandomItems; i++) begin
            idle_phase <= (i * 3) / RandomItems;
            pick_random(op, value, trits, count);
            offer_item(op, value, trits, count, 1'b0, NoRes);
        end
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

### filelist.f
rtl/btc_pkg.sv
rtl/btc_front.sv
rtl/btc_mid.sv
rtl/btc_back.sv
rtl/balanced_ternary_converter.sv
verif/tb_top.sv
